// ===== sv/ctfp_pkg.sv =====
// Shared types and constants for the CAN transmit frame packer.
`timescale 1ns / 1ps

package ctfp_pkg;

    localparam int DEST_W   = 5;
    localparam int WORD_W   = 16;
    localparam int ID_W     = 11;
    localparam int LEN_W    = 4;
    localparam int ADDR_W   = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 96;

    // words per stored triple, and per two-pair frame
    localparam int SET_WORDS  = 3;
    localparam int PAIR_WORDS = 6;

    // frame length codes
    localparam logic [LEN_W-1:0] LEN_NONE = 4'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 4'd4;
    localparam logic [LEN_W-1:0] LEN_MORE = 4'd8;
    localparam logic [LEN_W-1:0] LEN_LAST = 4'd9;

    localparam logic [ID_W-1:0] ID_EMPTY = 11'd1;
    localparam logic [ID_W-1:0] ID_ERROR = 11'd0;

    // command handed from the front to the back
    typedef struct packed {
        logic              is_req;
        logic [DEST_W-1:0] dest;
        logic [WORD_W-1:0] index;
        logic [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  frame_length;
        logic [WORD_W-1:0] data_word0;
        logic [WORD_W-1:0] data_word1;
        logic [WORD_W-1:0] data_word2;
        logic [WORD_W-1:0] data_word3;
        logic              set_error;
        logic [WORD_W-1:0] error_count;
    } res_t;

endpackage

// ===== sv/can_tx_frame_packer.sv =====
// Top level of the CAN transmit frame packer.
`timescale 1ns / 1ps
//
//  channel  dir  tdata                                   tuser
//  s_       in   dest, index, value (40 bits)             kind (1 = frame request)
//  m_       out  id, length, 4 data words, error count    set_error
//  cfg_     in   own_address                              -
//
// A push in the back end is a decision, then three memory writes.
// A frame request is the decision, seven memory reads, a wait for the registered
// read data, and the frame build; empty and flush requests finish at the decision.
// Two commands queue ahead of the back end; s_tready drops once both slots are taken.
// A waiting result holds the back end only at the next frame request.
// aresetn is synchronous; it empties the queue and FIFO and clears the error count.

module can_tx_frame_packer #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ctfp_pkg::ADDR_W-1:0]    cfg_wr_data,   // own_address
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ctfp_pkg::S_DATA_W-1:0]  s_tdata,       // dest, index, value
    input  logic                           s_tuser,       // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_id, frame_length, data_word0..3, error_count
    output logic [ctfp_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tuser        // set_error
);
    import ctfp_pkg::*;

    logic [ADDR_W-1:0] own_address_reg;
    logic              cmd_valid;
    logic              cmd_ready;
    cmd_t              cmd;
    res_t              res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= '0;
        end else if (cfg_wr_en) begin
            own_address_reg <= cfg_wr_data;
        end
    end

    ctfp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ctfp_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .own_address (own_address_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {1'b0, res.error_count, res.data_word3, res.data_word2,
                      res.data_word1, res.data_word0, res.frame_length, res.frame_id};
    assign m_tuser = res.set_error;

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.set_error |->
            res.frame_length == LEN_NONE && res.frame_id == ID_ERROR)
        else $error("flush result carries a frame");

    a_length_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.frame_length == LEN_NONE || res.frame_length == LEN_ONE ||
                     res.frame_length == LEN_MORE || res.frame_length == LEN_LAST)
        else $error("bad frame length code");

    a_single_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.frame_length == LEN_ONE |->
            res.data_word2 == '0 && res.data_word3 == '0)
        else $error("single pair frame has stale second pair");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd_valid |-> s_tready)
        else $error("empty command queue refuses input");

endmodule

// ===== sv/ctfp_front.sv =====
// Input side: accepts words, classifies them and queues commands for the back end.
`timescale 1ns / 1ps

module ctfp_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ctfp_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output ctfp_pkg::cmd_t                 cmd
);
    import ctfp_pkg::*;

    cmd_t       q_reg [0:1];
    logic       head_reg, head_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       in_cmd;
    logic       tail;
    logic       do_push, do_pop;

    always_comb begin
        in_cmd.is_req = s_tuser;
        in_cmd.dest   = s_tdata[DEST_W-1:0];
        in_cmd.index  = s_tdata[DEST_W+WORD_W-1:DEST_W];
        in_cmd.value  = s_tdata[DEST_W+2*WORD_W-1:DEST_W+WORD_W];
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[head_reg];
    assign do_push   = s_tvalid && s_tready;
    assign do_pop    = cmd_valid && cmd_ready;
    assign tail      = head_reg ^ fill_reg[0];

    always_comb begin
        head_next = head_reg ^ do_pop;
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_reg[tail] <= in_cmd;
        end
    end

endmodule

// ===== sv/ctfp_back.sv =====
// Back end: word FIFO memory, push writer, frame builder and result register.
`timescale 1ns / 1ps

module ctfp_back #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ctfp_pkg::ADDR_W-1:0]   own_address,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  ctfp_pkg::cmd_t                cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ctfp_pkg::res_t                res
);
    import ctfp_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W:0]   DEPTH_W    = (PTR_W + 1)'(FIFO_DEPTH);
    localparam logic [CNT_W-1:0] PUSH_LIMIT = CNT_W'(FIFO_DEPTH - SET_WORDS);
    localparam logic [CNT_W-1:0] CNT_SET    = CNT_W'(SET_WORDS);
    localparam logic [CNT_W-1:0] CNT_PAIR   = CNT_W'(PAIR_WORDS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WRITE  = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // seven words are fetched per request: dest, index, value, next dest,
    // index, value, and the dest after that
    localparam logic [2:0] LAST_STEP = 3'd7;

    logic [WORD_W-1:0] mem [0:FIFO_DEPTH-1];

    logic [1:0]        state_reg, state_next;
    logic [2:0]        step_reg, step_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] err_cnt_reg, err_cnt_next;
    logic [DEST_W-1:0] dest_reg, dest_next;
    logic [WORD_W-1:0] index_reg, index_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [WORD_W-1:0] word_reg [0:6];
    logic [WORD_W-1:0] word_next [0:6];
    logic [WORD_W-1:0] rd_data_reg;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic              mem_we;
    logic [WORD_W-1:0] wr_word;
    logic [PTR_W-1:0]  rd_addr;
    logic              out_free;
    logic              match_pair;
    logic              more_follow;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                  input logic [2:0] k);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W + 1)'(k);
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[PTR_W-1:0];
    endfunction

    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign rd_addr   = wrap_add(rp_reg, step_reg);

    assign match_pair  = (count_reg >= CNT_PAIR) && (word_reg[3] == word_reg[0]);
    assign more_follow = (count_reg > CNT_PAIR) && (word_reg[6] == word_reg[0]);

    always_comb begin
        unique case (step_reg)
            3'd0:    wr_word = WORD_W'(dest_reg);
            3'd1:    wr_word = index_reg;
            default: wr_word = value_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        count_next     = count_reg;
        err_cnt_next   = err_cnt_reg;
        dest_next      = dest_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        word_next      = word_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && !cmd.is_req) begin
                    cmd_ready = 1'b1;
                    if (count_reg < PUSH_LIMIT) begin
                        dest_next  = cmd.dest;
                        index_next = cmd.index;
                        value_next = cmd.value;
                        step_next  = 3'd0;
                        state_next = ST_WRITE;
                    end
                end else if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    priority if (count_reg == '0) begin
                        res_next              = '0;
                        res_next.frame_id     = ID_EMPTY;
                        res_next.frame_length = LEN_NONE;
                        res_next.error_count  = err_cnt_reg;
                        res_valid_next        = 1'b1;
                    end else if (count_reg == CNT_SET || count_reg >= CNT_PAIR) begin
                        step_next  = 3'd0;
                        state_next = ST_READ;
                    end else begin
                        // not a whole number of triples: flush
                        err_cnt_next          = err_cnt_reg + 16'd1;
                        wp_next               = '0;
                        rp_next               = '0;
                        count_next            = '0;
                        res_next              = '0;
                        res_next.frame_id     = ID_ERROR;
                        res_next.set_error    = 1'b1;
                        res_next.error_count  = err_cnt_reg + 16'd1;
                        res_valid_next        = 1'b1;
                    end
                end
            end
            ST_WRITE: begin
                mem_we     = 1'b1;
                wp_next    = wrap_add(wp_reg, 3'd1);
                count_next = count_reg + CNT_W'(1);
                step_next  = step_reg + 3'd1;
                if (step_reg == 3'd2) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                // read data is registered: it arrives in the cycle after its address
                if (step_reg != 3'd0) begin
                    for (int i = 0; i < 6; i++) begin
                        word_next[i] = word_reg[i+1];
                    end
                    word_next[6] = rd_data_reg;
                end
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_FINISH;
                end
            end
            default: begin
                res_next.frame_id   = {word_reg[0][DEST_W-1:0], 1'b0, own_address};
                res_next.data_word0 = word_reg[1];
                res_next.data_word1 = word_reg[2];
                res_next.set_error  = 1'b0;
                res_next.error_count = err_cnt_reg;
                if (match_pair) begin
                    res_next.frame_length = more_follow ? LEN_MORE : LEN_LAST;
                    res_next.data_word2   = word_reg[4];
                    res_next.data_word3   = word_reg[5];
                    rp_next               = wrap_add(rp_reg, 3'(PAIR_WORDS));
                    count_next            = count_reg - CNT_PAIR;
                end else begin
                    res_next.frame_length = LEN_ONE;
                    res_next.data_word2   = '0;
                    res_next.data_word3   = '0;
                    rp_next               = wrap_add(rp_reg, 3'(SET_WORDS));
                    count_next            = count_reg - CNT_SET;
                end
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 3'd0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            err_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            count_reg     <= count_next;
            err_cnt_reg   <= err_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dest_reg  <= dest_next;
        index_reg <= index_next;
        value_reg <= value_next;
        word_reg  <= word_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= wr_word;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== tb/tb_can_tx_frame_packer.sv =====
// Self-checking testbench for the CAN transmit frame packer.
`timescale 1ns / 1ps

module tb_can_tx_frame_packer;

    import ctfp_pkg::*;

    localparam int FIFO_DEPTH = 64;
    localparam int SETTLE_CYCLES = 40;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;   // dest, index, value (lowest first)
    logic                  s_tuser = 1'b0; // kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;        // id, length, data words 0..3, error count
    logic                  m_tuser;        // set_error

    can_tx_frame_packer #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- frame predictor ----------------
    logic [WORD_W-1:0] word_ring [FIFO_DEPTH];
    int                ring_wr = 0;
    int                ring_rd = 0;
    int                words_held = 0;
    logic [WORD_W-1:0] mismatch_tally = '0;
    logic [ADDR_W-1:0] own_addr_shadow = '0;

    res_t frames_due [$];

    int fail_count = 0;
    int items_taken = 0;
    int pushes_dropped = 0;
    int len_seen [16];
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold = 0;
    logic [DEST_W-1:0] hot_a, hot_b;

    function automatic void store_word(input logic [WORD_W-1:0] w);
        word_ring[ring_wr] = w;
        ring_wr = (ring_wr + 1) % FIFO_DEPTH;
        words_held++;
    endfunction

    function automatic logic [WORD_W-1:0] take_word();
        logic [WORD_W-1:0] w;
        w = '0;
        if (words_held > 0) begin
            w = word_ring[ring_rd];
            ring_rd = (ring_rd + 1) % FIFO_DEPTH;
            words_held--;
        end
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] peek_word();
        return (words_held > 0) ? word_ring[ring_rd] : '0;
    endfunction

    // Applies one input word to the shadow FIFO; returns 1 when a frame comes out.
    function automatic bit pack_frame(input logic kind, input logic [DEST_W-1:0] dest,
                                      input logic [WORD_W-1:0] idx, input logic [WORD_W-1:0] val,
                                      output res_t fr);
        int                start;
        logic [WORD_W-1:0] addr;
        fr = '0;
        if (kind == KIND_PUSH) begin
            if (words_held < FIFO_DEPTH - SET_WORDS) begin
                store_word(WORD_W'(dest));
                store_word(idx);
                store_word(val);
            end
            return 1'b0;
        end
        if (words_held == 0) begin
            fr.frame_id = ID_EMPTY;
            fr.frame_length = LEN_NONE;
        end else if (words_held >= PAIR_WORDS || words_held == SET_WORDS) begin
            start = words_held;
            addr = take_word();
            fr.frame_id = ID_W'({addr, 6'd0} + own_addr_shadow);
            fr.data_word0 = take_word();
            fr.data_word1 = take_word();
            fr.frame_length = LEN_ONE;
            // second pair only when the next triple goes to the same board
            if (start >= PAIR_WORDS && peek_word() == addr) begin
                void'(take_word());
                fr.data_word2 = take_word();
                fr.data_word3 = take_word();
                fr.frame_length = (start > PAIR_WORDS && peek_word() == addr) ? LEN_MORE
                                                                               : LEN_LAST;
            end
        end else begin
            mismatch_tally++;
            ring_wr = 0;
            ring_rd = 0;
            words_held = 0;
            fr.frame_id = ID_ERROR;
            fr.frame_length = LEN_NONE;
            fr.set_error = 1'b1;
        end
        fr.error_count = mismatch_tally;
        return 1'b1;
    endfunction

    // ---------------- sender side ----------------
    task automatic send_word(input logic kind, input logic [DEST_W-1:0] dest,
                             input logic [WORD_W-1:0] idx, input logic [WORD_W-1:0] val,
                             input bit use_typed = 1'b0, input res_t typed_frame = '0);
        res_t fr;
        bit   has_frame;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, val, idx, dest};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_taken++;
        if (kind == KIND_PUSH && words_held >= FIFO_DEPTH - SET_WORDS)
            pushes_dropped++;
        has_frame = pack_frame(kind, dest, idx, val, fr);
        if (has_frame)
            frames_due.push_back(use_typed ? typed_frame : fr);
    endtask

    // wait for the last frame, then let any trailing push finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_own_address(input logic [ADDR_W-1:0] a);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        own_addr_shadow = a;
    endtask

    function automatic logic [DEST_W-1:0] pick_dest();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return hot_a;
        if (r < 75) return hot_b;
        return DEST_W'($urandom_range(0, 31));
    endfunction

    // Mostly runs of triples for a couple of boards, so multi-pair frames happen;
    // occasional fill bursts push the FIFO past full.
    task automatic run_random(input int n_items);
        int target;
        int r;
        logic [DEST_W-1:0] d;
        target = items_taken + n_items;
        hot_a = DEST_W'($urandom_range(0, 31));
        hot_b = DEST_W'($urandom_range(0, 31));
        while (items_taken < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                repeat (22) send_word(KIND_PUSH, pick_dest(), 16'($urandom), 16'($urandom));
            end else if (r < 60) begin
                d = pick_dest();
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0) d = pick_dest();
                    send_word(KIND_PUSH, d, 16'($urandom), 16'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 3))
                    send_word(KIND_REQ, DEST_W'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    // ---------------- directed words ----------------
    typedef struct {
        logic              kind;
        logic [DEST_W-1:0] dest;
        logic [WORD_W-1:0] idx;
        logic [WORD_W-1:0] val;
        bit                typed;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] d0, d1, d2, d3;
        logic              err;
        logic [WORD_W-1:0] cnt;
    } dir_row_t;

    // kind, dest, index, value, typed, id, length, d0..d3, error, count
    dir_row_t dir_rows [21] = '{
        '{KIND_REQ,   0, 'h0000, 'h0000, 1, ID_EMPTY, LEN_NONE, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH, 31, 'hffff, 'hffff, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_REQ,   0, 'h0000, 'h0000, 1, 11'd1984, LEN_ONE, 'hffff, 'hffff, 0, 0, 0, 0},
        '{KIND_PUSH,  0, 'h0000, 'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_REQ,   0, 'h0000, 'h0000, 1, 11'd0, LEN_ONE, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH,  5, 'h1234, 'habcd, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH,  5, 'h8000, 'h0001, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH,  5, 'h7fff, 'hfffe, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH,  7, 'h0055, 'h00aa, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_REQ,   0, 'h0000, 'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_REQ,   0, 'h0000, 'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_REQ,   0, 'h0000, 'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH,  9, 'h5a5a, 'ha5a5, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH,  9, 'h0f0f, 'hf0f0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_REQ,   0, 'h0000, 'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_REQ,  31, 'hffff, 'hffff, 1, ID_EMPTY, LEN_NONE, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH, 18, 'h0001, 'h0002, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH, 18, 'h0003, 'h0004, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_PUSH,  3, 'h0005, 'h0006, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_REQ,   0, 'h0000, 'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{KIND_REQ,   0, 'h0000, 'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    // ---------------- receiver side ----------------
    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : rx_side
        res_t want;
        if (m_tvalid && m_tready) begin
            if (frames_due.size() == 0) begin
                $error("frame word with no request pending");
                fail_count++;
            end else begin
                want = frames_due.pop_front();
                check_field("frame_id",     WORD_W'(want.frame_id),     WORD_W'(m_tdata[10:0]));
                check_field("frame_length", WORD_W'(want.frame_length), WORD_W'(m_tdata[14:11]));
                check_field("data_word0",   want.data_word0,  m_tdata[30:15]);
                check_field("data_word1",   want.data_word1,  m_tdata[46:31]);
                check_field("data_word2",   want.data_word2,  m_tdata[62:47]);
                check_field("data_word3",   want.data_word3,  m_tdata[78:63]);
                check_field("error_count",  want.error_count, m_tdata[94:79]);
                check_field("set_error",    WORD_W'(want.set_error), WORD_W'(m_tuser));
                len_seen[m_tdata[14:11]]++;
            end
        end
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ---------------- main sequence ----------------
    initial begin : main_seq
        res_t typed_frame;
        foreach (len_seen[i]) len_seen[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_own_address('0);

        foreach (dir_rows[i]) begin
            typed_frame = '{dir_rows[i].id, dir_rows[i].len, dir_rows[i].d0, dir_rows[i].d1,
                            dir_rows[i].d2, dir_rows[i].d3, dir_rows[i].err, dir_rows[i].cnt};
            send_word(dir_rows[i].kind, dir_rows[i].dest, dir_rows[i].idx, dir_rows[i].val,
                      dir_rows[i].typed, typed_frame);
        end
        settle();

        set_own_address(5'd31);
        tx_idle_pct = 36;
        rx_idle_pct = 66;
        run_random(440);
        settle();

        set_own_address(ADDR_W'($urandom_range(1, 30)));
        tx_idle_pct = 66;
        rx_idle_pct = 36;
        run_random(440);
        settle();

        set_own_address(ADDR_W'($urandom_range(0, 31)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(440);
        settle();

        // receiver stalls while requests pile up ahead of the back end
        set_own_address(ADDR_W'($urandom_range(0, 31)));
        rx_hold = 400;
        repeat (6) send_word(KIND_PUSH, hot_a, 16'($urandom), 16'($urandom));
        repeat (8) send_word(KIND_REQ, DEST_W'($urandom), 16'($urandom), 16'($urandom));
        settle();

        $display("Took %0d words (%0d pushes dropped on a full FIFO), five own addresses.",
                 items_taken, pushes_dropped);
        $display("Frames: %0d empty, %0d single pair, %0d more to follow, %0d last.",
                 len_seen[LEN_NONE], len_seen[LEN_ONE], len_seen[LEN_MORE], len_seen[LEN_LAST]);
        if (fail_count == 0 && frames_due.size() == 0) begin
            $display("can_tx_frame_packer test passed");
        end else begin
            $display("can_tx_frame_packer test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("can_tx_frame_packer test failed");
        $finish;
    end

endmodule
